/* rtl/bped_pkg.sv */
// bped_pkg: shared types and constants of the button event detector
// used by bped_lane, bped_merge and the top level; no dependencies

package bped_pkg;

   // width of the scanned level field and of the time fields
   localparam int LEVEL_W = 9;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int INDEX_W = 4;
   localparam int SLOTS   = 3;

   // register reset values
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET    = 16'd1000;
   localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RESET = 16'd300;

   // configuration register indexes
   localparam logic [1:0] CSR_LONG_PRESS    = 2'd0;
   localparam logic [1:0] CSR_DOUBLE_WINDOW = 2'd1;

   // release tally value that completes a double press
   localparam logic [1:0] TALLY_DOUBLE = 2'd2;

   typedef enum logic [1:0] {
      KIND_PRESS   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_LONG    = 2'd2,
      KIND_DOUBLE  = 2'd3
   } kind_type;

   // up to three events one button produces in one scan, in emit order
   typedef struct packed {
      logic [SLOTS-1:0]      mask;
      kind_type [SLOTS-1:0]  kind;
      logic [TIME_W-1:0]     held;
   } lane_evt_type;

endpackage

/* rtl/bped_lane.sv */
// bped_lane: per-button edge, long-press and double-press logic with its state
// depends on bped_pkg

module bped_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           level,
   input  logic [bped_pkg::TIME_W-1:0]    now,
   input  logic [bped_pkg::CFG_W-1:0]     long_ms,
   input  logic [bped_pkg::CFG_W-1:0]     window_ms,
   input  logic                           take,
   output bped_pkg::lane_evt_type         evt
);

   logic                          prev_ff, prev_in;
   logic [bped_pkg::TIME_W-1:0]   start_ff, start_in;
   logic [bped_pkg::TIME_W-1:0]   release_ff, release_in;
   logic [1:0]                    tally_ff, tally_in;
   logic                          long_rep_ff, long_rep_in;

   logic [bped_pkg::TIME_W-1:0]   held;
   logic [bped_pkg::TIME_W-1:0]   gap;
   logic [1:0]                    tally_inc;
   logic                          long_hit;
   logic                          long_zero;
   logic                          gap_ok;

   always_comb begin
      held      = now - start_ff;
      gap       = now - release_ff;
      long_hit  = held >= bped_pkg::TIME_W'(long_ms);
      long_zero = long_ms == '0;
      gap_ok    = gap <= bped_pkg::TIME_W'(window_ms);
      tally_inc = tally_ff + 2'd1;

      prev_in     = prev_ff;
      start_in    = start_ff;
      release_in  = release_ff;
      tally_in    = tally_ff;
      long_rep_in = long_rep_ff;

      evt.mask    = '0;
      evt.kind[0] = bped_pkg::KIND_PRESS;
      evt.kind[1] = bped_pkg::KIND_LONG;
      evt.kind[2] = bped_pkg::KIND_DOUBLE;
      evt.held    = held;

      if (level && !prev_ff) begin
         // rising: press, and a long press right away on a zero threshold
         prev_in     = 1'b1;
         start_in    = now;
         long_rep_in = long_zero;
         evt.mask    = {1'b0, long_zero, 1'b1};
         evt.held    = '0;
      end else if (!level && prev_ff) begin
         // falling: pending long press, release, then double press check
         prev_in     = 1'b0;
         release_in  = now;
         evt.kind[0] = bped_pkg::KIND_LONG;
         evt.kind[1] = bped_pkg::KIND_RELEASE;
         evt.mask[0] = long_hit && !long_rep_ff;
         evt.mask[1] = 1'b1;
         if (long_hit) begin
            long_rep_in = 1'b1;
         end
         if (gap_ok) begin
            if (tally_inc == bped_pkg::TALLY_DOUBLE) begin
               evt.mask[2] = 1'b1;
               tally_in    = 2'd0;
            end else begin
               tally_in = tally_inc;
            end
         end else begin
            tally_in = 2'd1;
         end
      end else if (level && !long_rep_ff && long_hit) begin
         // still held: long press once the threshold is reached
         evt.kind[0] = bped_pkg::KIND_LONG;
         evt.mask[0] = 1'b1;
         long_rep_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= 1'b0;
         start_ff    <= '0;
         release_ff  <= '0;
         tally_ff    <= 2'd0;
         long_rep_ff <= 1'b0;
      end else if (take) begin
         prev_ff     <= prev_in;
         start_ff    <= start_in;
         release_ff  <= release_in;
         tally_ff    <= tally_in;
         long_rep_ff <= long_rep_in;
      end
   end

endmodule

/* rtl/bped_merge.sv */
// bped_merge: holds one scan's lane events and sends them out one per cycle while
// rsp_stall is low, in button order through the output register; depends on bped_pkg

module bped_merge #(
   parameter int NUM_BUTTONS = 9
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bped_pkg::lane_evt_type          evt [NUM_BUTTONS],
   input  logic [bped_pkg::TIME_W-1:0]     now,
   input  logic                            load,
   output logic                            take_ok,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bped_pkg::INDEX_W-1:0]    rsp_button_index,
   output logic [1:0]                      rsp_event_kind,
   output logic [bped_pkg::TIME_W-1:0]     rsp_held_ms,
   output logic [bped_pkg::TIME_W-1:0]     rsp_stamp_ms,
   output logic                            rsp_last_event
);

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   logic [bped_pkg::SLOTS-1:0]          mask_ff [NUM_BUTTONS];
   logic [bped_pkg::SLOTS-1:0]          mask_in [NUM_BUTTONS];
   logic [bped_pkg::SLOTS-1:0]          mask_rest [NUM_BUTTONS];
   bped_pkg::kind_type [bped_pkg::SLOTS-1:0] kind_ff [NUM_BUTTONS];
   logic [bped_pkg::TIME_W-1:0]         held_ff [NUM_BUTTONS];
   logic [bped_pkg::TIME_W-1:0]         stamp_ff;

   logic                                valid_ff, valid_in;
   logic [bped_pkg::INDEX_W-1:0]        index_ff, index_in;
   logic [1:0]                          kind_out_ff, kind_out_in;
   logic [bped_pkg::TIME_W-1:0]         held_out_ff, held_out_in;
   logic [bped_pkg::TIME_W-1:0]         stamp_out_ff;
   logic                                last_ff, last_in;

   logic                                out_load;
   logic                                found;
   logic [IDX_W-1:0]                    pick_lane;
   logic [1:0]                          pick_slot;
   logic [bped_pkg::SLOTS-1:0]          pick_bit;
   logic [bped_pkg::SLOTS-1:0]          lane_mask;
   bped_pkg::kind_type                  pick_kind;
   logic                                any_rest;
   logic [31:0]                         lane_wide;

   assign out_load = !valid_ff || !rsp_stall;

   // lowest button with something left, then its earliest slot
   always_comb begin
      found     = 1'b0;
      pick_lane = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (mask_ff[i] != '0) begin
            found     = 1'b1;
            pick_lane = IDX_W'(i);
         end
      end
      lane_mask = mask_ff[pick_lane];
      if (lane_mask[0]) begin
         pick_slot = 2'd0;
      end else if (lane_mask[1]) begin
         pick_slot = 2'd1;
      end else begin
         pick_slot = 2'd2;
      end
      pick_bit  = bped_pkg::SLOTS'(1) << pick_slot;
      pick_kind = kind_ff[pick_lane][pick_slot];
      any_rest  = 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         mask_rest[i] = mask_ff[i];
         if (IDX_W'(i) == pick_lane) begin
            mask_rest[i] = mask_ff[i] & ~pick_bit;
         end
         any_rest = any_rest | (mask_rest[i] != '0);
      end
   end

   assign take_ok = !found || (!any_rest && out_load);

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (load) begin
            mask_in[i] = evt[i].mask;
         end else if (out_load && found) begin
            mask_in[i] = mask_rest[i];
         end else begin
            mask_in[i] = mask_ff[i];
         end
      end
      lane_wide   = 32'(pick_lane);
      valid_in    = found;
      index_in    = lane_wide[bped_pkg::INDEX_W-1:0];
      kind_out_in = pick_kind;
      if (pick_kind == bped_pkg::KIND_LONG || pick_kind == bped_pkg::KIND_RELEASE) begin
         held_out_in = held_ff[pick_lane];
      end else begin
         held_out_in = '0;
      end
      last_in = !any_rest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            mask_ff[i] <= '0;
         end
         valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            mask_ff[i] <= mask_in[i];
         end
         if (out_load) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            kind_ff[i] <= evt[i].kind;
            held_ff[i] <= evt[i].held;
         end
         stamp_ff <= now;
      end
      if (out_load) begin
         index_ff     <= index_in;
         kind_out_ff  <= kind_out_in;
         held_out_ff  <= held_out_in;
         stamp_out_ff <= stamp_ff;
         last_ff      <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_button_index = index_ff;
   assign rsp_event_kind   = kind_out_ff;
   assign rsp_held_ms      = held_out_ff;
   assign rsp_stamp_ms     = stamp_out_ff;
   assign rsp_last_event   = last_ff;

endmodule

/* rtl/button_press_event_detector.sv */
// button_press_event_detector: top level, config registers, one lane per button
// depends on bped_pkg, bped_lane and bped_merge
// path: a scan's events are registered in the merge stage, then leave through its output register
// throughput: one event per cycle while rsp_stall is low; a scan holds the input until its last
//   event moves into the single output register the merge stage drains into (a quiet scan does not hold it)
// reset (synchronous): clears all button state and loads 1000 ms / 300 ms thresholds

module button_press_event_detector #(
   parameter int NUM_BUTTONS = 9
) (
   input  logic                            clock,
   input  logic                            reset,
   // scan transaction
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bped_pkg::LEVEL_W-1:0]    req_button_levels,
   input  logic [bped_pkg::TIME_W-1:0]     req_now_ms,
   // event transaction
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bped_pkg::INDEX_W-1:0]    rsp_button_index,
   output logic [1:0]                      rsp_event_kind,
   output logic [bped_pkg::TIME_W-1:0]     rsp_held_ms,
   output logic [bped_pkg::TIME_W-1:0]     rsp_stamp_ms,
   output logic                            rsp_last_event,
   // configuration writes
   input  logic                            csr_wr_en,
   input  logic [1:0]                      csr_index,
   input  logic [bped_pkg::CFG_W-1:0]      csr_wr_data
);

   logic [bped_pkg::CFG_W-1:0] long_ms_ff, long_ms_in;
   logic [bped_pkg::CFG_W-1:0] window_ff, window_in;

   logic                       take_ok;
   logic                       take;
   bped_pkg::lane_evt_type     lane_evt [NUM_BUTTONS];

   // config writes; unknown indexes fall through and change nothing
   always_comb begin
      long_ms_in = long_ms_ff;
      window_in  = window_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bped_pkg::CSR_LONG_PRESS:    long_ms_in = csr_wr_data;
            bped_pkg::CSR_DOUBLE_WINDOW: window_in  = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ms_ff <= bped_pkg::LONG_PRESS_RESET;
         window_ff  <= bped_pkg::DOUBLE_WINDOW_RESET;
      end else begin
         long_ms_ff <= long_ms_in;
         window_ff  <= window_in;
      end
   end

   // a scan is taken when the merge stage empties in this cycle or is empty
   assign req_stall = !take_ok;
   assign take      = req_valid && take_ok;

   // one lane per button; buttons past the level field always read released
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic lane_level;
      if (i < bped_pkg::LEVEL_W) begin : g_in
         assign lane_level = req_button_levels[i];
      end else begin : g_off
         assign lane_level = 1'b0;
      end

      bped_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .level     (lane_level),
         .now       (req_now_ms),
         .long_ms   (long_ms_ff),
         .window_ms (window_ff),
         .take      (take),
         .evt       (lane_evt[i])
      );
   end

   // serialize the scan's events in button order, last one flagged
   bped_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock            (clock),
      .reset            (reset),
      .evt              (lane_evt),
      .now              (req_now_ms),
      .load             (take),
      .take_ok          (take_ok),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_button_index (rsp_button_index),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_held_ms      (rsp_held_ms),
      .rsp_stamp_ms     (rsp_stamp_ms),
      .rsp_last_event   (rsp_last_event)
   );

endmodule

/* rtl/bped_checker.sv */
// bped_checker: port-level assertions for the button event detector
// depends on bped_pkg; bound to button_press_event_detector below

module bped_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [bped_pkg::INDEX_W-1:0]    rsp_button_index,
   input logic [1:0]                      rsp_event_kind,
   input logic [bped_pkg::TIME_W-1:0]     rsp_held_ms,
   input logic [bped_pkg::TIME_W-1:0]     rsp_stamp_ms,
   input logic                            rsp_last_event
);

   // stalled event transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_button_index)
         && $stable(rsp_event_kind) && $stable(rsp_held_ms)
         && $stable(rsp_stamp_ms) && $stable(rsp_last_event))
      else $error("event changed while stalled");

   // press and double press carry no duration
   a_held_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == bped_pkg::KIND_PRESS
         || rsp_event_kind == bped_pkg::KIND_DOUBLE) |-> rsp_held_ms == '0)
      else $error("held time on press or double press");

   // events of one scan follow without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_event |=> rsp_valid)
      else $error("gap inside a scan's events");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("event valid after reset");

endmodule

bind button_press_event_detector bped_checker u_bped_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_button_index (rsp_button_index),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_held_ms      (rsp_held_ms),
   .rsp_stamp_ms     (rsp_stamp_ms),
   .rsp_last_event   (rsp_last_event)
);

/* tb/testbench.sv */
// testbench: self-checking bench for button_press_event_detector
// sends scans on the req_ channel, predicts every event from its own copy of the
// per-button state and compares each rsp_ transaction in order; depends on bped_pkg

module testbench;

   localparam int NUM_BUTTONS  = 9;
   localparam int DRAIN_CYCLES = 8;         // two-stage output path plus slack
   localparam int MAX_REPORTS  = 10;
   localparam int RUN_LIMIT    = 5_000_000; // time units, far above the slowest run

   // register indexes with no register behind them; writes must be ignored
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   typedef struct {
      logic [bped_pkg::INDEX_W-1:0] index;
      bped_pkg::kind_type           kind;
      logic [bped_pkg::TIME_W-1:0]  held;
      logic [bped_pkg::TIME_W-1:0]  stamp;
      logic                         last;
   } scan_event_type;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   // every input of the block starts at a known value
   logic                          clock             = 1'b0;
   logic                          reset             = 1'b1;
   logic                          req_valid         = 1'b0;
   logic                          req_stall;
   logic [bped_pkg::LEVEL_W-1:0]  req_button_levels = '0;
   logic [bped_pkg::TIME_W-1:0]   req_now_ms        = '0;
   logic                          rsp_valid;
   logic                          rsp_stall         = 1'b0;
   logic [bped_pkg::INDEX_W-1:0]  rsp_button_index;
   logic [1:0]                    rsp_event_kind;
   logic [bped_pkg::TIME_W-1:0]   rsp_held_ms;
   logic [bped_pkg::TIME_W-1:0]   rsp_stamp_ms;
   logic                          rsp_last_event;
   logic                          csr_wr_en         = 1'b0;
   logic [1:0]                    csr_index         = '0;
   logic [bped_pkg::CFG_W-1:0]    csr_wr_data       = '0;

   // predicted per-button state and thresholds, mirroring the block after reset
   logic                          btn_level     [NUM_BUTTONS] = '{default: 1'b0};
   logic [bped_pkg::TIME_W-1:0]   btn_press_t   [NUM_BUTTONS] = '{default: '0};
   logic [bped_pkg::TIME_W-1:0]   btn_release_t [NUM_BUTTONS] = '{default: '0};
   logic [1:0]                    btn_tally     [NUM_BUTTONS] = '{default: '0};
   logic                          btn_long_sent [NUM_BUTTONS] = '{default: 1'b0};
   logic [bped_pkg::CFG_W-1:0]    long_thr = bped_pkg::LONG_PRESS_RESET;
   logic [bped_pkg::CFG_W-1:0]    dbl_win  = bped_pkg::DOUBLE_WINDOW_RESET;

   scan_event_type                expected_events [$];
   int                            error_count = 0;
   int                            burst_left  = 0;
   logic [bped_pkg::TIME_W-1:0]   scan_clock  = '0;

   stall_mode_type                stall_mode = STALL_NONE;
   int                            stall_run  = 0;

   button_press_event_detector #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_button_levels (req_button_levels),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_button_index  (rsp_button_index),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_held_ms       (rsp_held_ms),
      .rsp_stamp_ms      (rsp_stamp_ms),
      .rsp_last_event    (rsp_last_event),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure: switches at random between stall styles,
   // including quiet stretches and near-solid stalls
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_run  <= $urandom_range(20, 80);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PERIODIC: rsp_stall <= ((stall_run % 5) < 2);
         default:        rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%s", msg);
   endfunction

   // predict the events of one accepted scan; buttons in index order, and per button:
   // press, then (on release) long press if still owed, release, double press,
   // then the held-level long-press check
   task automatic predict_scan(input logic [bped_pkg::LEVEL_W-1:0] levels,
                               input logic [bped_pkg::TIME_W-1:0] now);
      scan_event_type              scan_events [$];
      logic [bped_pkg::TIME_W-1:0] held;
      logic [bped_pkg::TIME_W-1:0] gap;
      logic                        lvl;
      int                          b;
      for (b = 0; b < NUM_BUTTONS; b++) begin
         // buttons beyond the level field always read as released
         lvl = (b < bped_pkg::LEVEL_W) ? levels[b] : 1'b0;
         if (lvl != btn_level[b]) begin
            if (lvl) begin
               btn_press_t[b]   = now;
               btn_long_sent[b] = 1'b0;
               scan_events.push_back('{4'(b), bped_pkg::KIND_PRESS, '0, now, 1'b0});
            end else begin
               held = now - btn_press_t[b];
               gap  = now - btn_release_t[b];   // measured from the previous release
               if (held >= long_thr && !btn_long_sent[b]) begin
                  scan_events.push_back('{4'(b), bped_pkg::KIND_LONG, held, now, 1'b0});
                  btn_long_sent[b] = 1'b1;
               end
               scan_events.push_back('{4'(b), bped_pkg::KIND_RELEASE, held, now, 1'b0});
               if (gap <= dbl_win) begin
                  btn_tally[b] = btn_tally[b] + 2'd1;
                  if (btn_tally[b] == bped_pkg::TALLY_DOUBLE) begin
                     scan_events.push_back('{4'(b), bped_pkg::KIND_DOUBLE, '0, now, 1'b0});
                     btn_tally[b] = '0;
                  end
               end else begin
                  btn_tally[b] = 2'd1;
               end
               btn_release_t[b] = now;
            end
            btn_level[b] = lvl;
         end
         if (lvl && !btn_long_sent[b]) begin
            held = now - btn_press_t[b];
            if (held >= long_thr) begin
               scan_events.push_back('{4'(b), bped_pkg::KIND_LONG, held, now, 1'b0});
               btn_long_sent[b] = 1'b1;
            end
         end
      end
      if (scan_events.size() > 0)
         scan_events[scan_events.size() - 1].last = 1'b1;
      foreach (scan_events[k])
         expected_events.push_back(scan_events[k]);
   endtask

   // one scan transaction; the sender works in bursts with random gaps between them.
   // valid is left high on return so back-to-back scans never drop it
   task automatic send_scan(input logic [bped_pkg::LEVEL_W-1:0] levels,
                            input logic [bped_pkg::TIME_W-1:0] now);
      int gap_cycles;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap_cycles) @(negedge clock) req_valid <= 1'b0;
      end
      burst_left--;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_button_levels <= levels;
      req_now_ms        <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_scan(levels, now);
   endtask

   // hold off the sender until every predicted event has come out, then let a
   // trailing quiet scan work its way through the block
   task automatic drain_events();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // only called while the block is idle
   task automatic write_csr(input logic [1:0] index,
                            input logic [bped_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == bped_pkg::CSR_LONG_PRESS)
         long_thr = value;
      else if (index == bped_pkg::CSR_DOUBLE_WINDOW)
         dbl_win = value;
   endtask

   task automatic set_thresholds(input logic [bped_pkg::CFG_W-1:0] long_ms,
                                 input logic [bped_pkg::CFG_W-1:0] window_ms);
      drain_events();
      write_csr(bped_pkg::CSR_LONG_PRESS, long_ms);
      write_csr(bped_pkg::CSR_DOUBLE_WINDOW, window_ms);
   endtask

   // reset thresholds (1000 / 300): every event kind; presses and long presses on all buttons at once
   task automatic test_basic_events();
      send_scan(9'h000, 32'd0);        // quiet scan, no events
      send_scan(9'h1FF, 32'd5);        // nine presses
      send_scan(9'h1FF, 32'd1004);     // one ms short of long press
      send_scan(9'h1FF, 32'd1005);     // long press exactly at threshold
      send_scan(9'h1FE, 32'd1100);     // button 0 release, far from last release
      send_scan(9'h1FF, 32'd1200);
      send_scan(9'h1FE, 32'd1300);     // second quick release: double press
   endtask

   // buttons 1..8 release for the first time: gap counted from time zero
   task automatic test_first_release();
      send_scan(9'h000, 32'd250);
   endtask

   // zero thresholds: long press in the press scan, double press needs a zero gap
   task automatic test_zero_thresholds();
      set_thresholds('0, '0);
      send_scan(9'h001, 32'd400);
      send_scan(9'h000, 32'd400);
      send_scan(9'h001, 32'd400);
      send_scan(9'h000, 32'd400);
   endtask

   // largest thresholds, time wrapping past 2^32, and writes to unused indexes
   task automatic test_wide_thresholds();
      set_thresholds('1, '1);
      write_csr(CSR_SPARE_A, '0);
      write_csr(CSR_SPARE_B, 16'h0001);
      send_scan(9'h100, 32'hFFFF_FFF0);
      send_scan(9'h100, 32'h0000_FFEF); // held wraps to exactly 65535
      send_scan(9'h000, 32'h0001_0000);
      send_scan(9'h100, 32'h0001_8000);
      send_scan(9'h000, 32'h0001_FFFF); // release gap exactly at the window
   endtask

   // gesture-like traffic: one focus button toggles most of the time, time steps
   // biased to land around the double-press window and the long-press threshold
   task automatic test_random_gestures(input logic [bped_pkg::CFG_W-1:0] long_ms,
                                       input logic [bped_pkg::CFG_W-1:0] window_ms,
                                       input logic [bped_pkg::TIME_W-1:0] start_ms,
                                       input int scans);
      logic [bped_pkg::LEVEL_W-1:0] levels;
      logic [bped_pkg::TIME_W-1:0]  now;
      int                           focus;
      int                           bit_sel;
      int                           step;
      set_thresholds(long_ms, window_ms);
      levels = req_button_levels;
      now    = start_ms;
      focus  = $urandom_range(0, bped_pkg::LEVEL_W - 1);
      repeat (scans) begin
         case ($urandom_range(0, 5))
            0, 1, 2: levels[focus] = ~levels[focus];
            3: begin
               bit_sel = $urandom_range(0, bped_pkg::LEVEL_W - 1);
               levels[bit_sel] = ~levels[bit_sel];
            end
            4: levels = levels ^ (bped_pkg::LEVEL_W'($urandom)
                                  & bped_pkg::LEVEL_W'($urandom));
            default: ;   // keep holding
         endcase
         if ($urandom_range(0, 7) == 0)
            step = 0;
         else if ($urandom_range(0, 1) == 1)
            step = $urandom_range(0, dbl_win);
         else
            step = $urandom_range(0, 2 * long_thr + 2);
         now = now + step;
         send_scan(levels, now);
         // now and then let the block run completely dry mid-sequence
         if ($urandom_range(0, 24) == 0)
            drain_events();
      end
      scan_clock = now;
   endtask

   // unstructured scans: any levels at any time, jumps backward included
   task automatic test_noise(input int scans);
      set_thresholds(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 500)));
      repeat (scans)
         send_scan(bped_pkg::LEVEL_W'($urandom), $urandom);
   endtask

   // compare each accepted event with the oldest prediction
   always @(posedge clock) begin : check_events
      scan_event_type head;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            report_error($sformatf("unexpected event: button %0d kind %0d held %0d stamp %0d",
                                   rsp_button_index, rsp_event_kind, rsp_held_ms,
                                   rsp_stamp_ms));
         end else begin
            head = expected_events.pop_front();
            if (rsp_button_index !== head.index || rsp_event_kind !== head.kind
                || rsp_held_ms !== head.held || rsp_stamp_ms !== head.stamp
                || rsp_last_event !== head.last)
               report_error($sformatf({"event mismatch: expected button %0d kind %s held %0d",
                                       " stamp %0d last %0b; got button %0d kind %0d",
                                       " held %0d stamp %0d last %0b"},
                                      head.index, head.kind.name(), head.held, head.stamp,
                                      head.last, rsp_button_index, rsp_event_kind,
                                      rsp_held_ms, rsp_stamp_ms, rsp_last_event));
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_basic_events();
      test_first_release();
      test_zero_thresholds();
      test_wide_thresholds();
      test_random_gestures(16'd1, 16'd1, 32'd5000, 28);
      test_random_gestures(16'($urandom_range(20, 200)), 16'($urandom_range(10, 150)),
                           scan_clock, 28);
      test_random_gestures(16'($urandom_range(20, 200)), 16'($urandom_range(10, 150)),
                           32'hFFFF_F000, 28);
      test_random_gestures('1, '1, scan_clock, 28);
      test_noise(24);
      drain_events();

      if (error_count == 0 && expected_events.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // hang guard
   initial begin
      #RUN_LIMIT;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
rtl/bped_pkg.sv
rtl/bped_lane.sv
rtl/bped_merge.sv
rtl/button_press_event_detector.sv
rtl/bped_checker.sv
tb/testbench.sv
